// ===== rtl/core/crsf_rc_frame_parser_core_assert.svh =====
// ============================================================================
// crsf_rc_frame_parser_core_assert.svh
// Assertion macros used by the frame parser RTL.
// ============================================================================
`ifndef CRSF_RC_FRAME_PARSER_CORE_ASSERT_SVH
`define CRSF_RC_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CRSF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crsf assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CRSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crsf assertion failed");

`endif

// ===== rtl/core/crsf_pkg.sv =====
// ============================================================================
// crsf_pkg
// Types, constants and the CRC-8 step shared by the frame parser.
// ============================================================================
`default_nettype none

package crsf_pkg;

   // Byte store of frame positions 3 through 24.
   localparam int STORE_DEPTH  = 22;
   localparam int STORE_FIRST  = 3;
   localparam int NUM_CHANNELS = 16;
   localparam int CHANNEL_BITS = 11;
   localparam int FRAME_BITS   = STORE_DEPTH * 8;

   // Frame queue between the parser and the channel emitter.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CRC_POLY      = 8'hD5;
   localparam logic [7:0] SYNC_RESET    = 8'hC8;
   localparam logic [7:0] CHTYPE_RESET  = 8'h16;

   // Register indexes of the configuration port.
   localparam logic [7:0] CSR_SYNC_VALUE    = 8'd0;
   localparam logic [7:0] CSR_CHANNELS_TYPE = 8'd1;

   typedef struct packed {
      logic [7:0] sync_value;
      logic [7:0] channels_type;
   } cfg_type;

   typedef logic [STORE_DEPTH-1:0][7:0] frame_data_type;

   // One byte of CRC-8, MSB first.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crsf_if.sv =====
// ============================================================================
// crsf_if
// Valid/ready channel interfaces of the frame parser.
// ============================================================================
`default_nettype none

// Received byte stream.
interface crsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded channel stream.
interface crsf_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  channel_number;
   logic [10:0] channel_value;
   logic        final_channel;
   modport source (output valid, output channel_number, output channel_value,
                   output final_channel, input ready);
   modport sink   (input valid, input channel_number, input channel_value,
                   input final_channel, output ready);
endinterface

// Register write channel.
interface crsf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/crsf_rc_frame_parser_core.sv =====
// ============================================================================
// crsf_rc_frame_parser_core
// Throughput: one byte per cycle; bytes stall only while the frame queue
// holds QUEUE_DEPTH frames. The emitter sends one channel per cycle while
// the consumer is ready. Channel 0 passes through the frame queue and
// the registered output stage; all sixteen channels follow in order.
// Reset (synchronous, active high) restores the registers, hunts for sync,
// clears the payload store and empties the frame queue.
// ============================================================================
`default_nettype none

module crsf_rc_frame_parser_core
   import crsf_pkg::*;
#(
   parameter int MAX_FRAME = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   crsf_req_if.sink    req_bus,
   crsf_rsp_if.source  rsp_bus,
   crsf_csr_if.sink    csr_bus
);

   cfg_type        cfg_ff, cfg_in;
   logic           q_full;
   logic           push;
   frame_data_type push_data;
   logic           pop;
   frame_data_type head_data;
   logic           head_valid;

   // Configuration registers; indexes beyond the list are ignored.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_SYNC_VALUE:    cfg_in.sync_value    = csr_bus.data;
            CSR_CHANNELS_TYPE: cfg_in.channels_type = csr_bus.data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value    <= SYNC_RESET;
         cfg_ff.channels_type <= CHTYPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crsf_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   crsf_queue #(
      .WIDTH (FRAME_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_data  (head_data),
      .head_valid (head_valid),
      .full       (q_full)
   );

   crsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (head_data),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== rtl/core/crsf_front.sv =====
// ============================================================================
// crsf_front
// Byte parser: sync hunt, length check, running CRC and payload store.
// A frame that checks out is pushed into the frame queue as a snapshot.
// ============================================================================
`default_nettype none

module crsf_front
   import crsf_pkg::*;
#(
   parameter int MAX_FRAME = 64
) (
   input  wire logic           clock,
   input  wire logic           reset,
   crsf_req_if.sink            req,
   input  wire cfg_type        cfg,
   input  wire logic           q_full,
   output logic                push,
   output frame_data_type      push_data
);

   logic [6:0]     pos_ff, pos_in;
   logic [7:0]     len_ff, len_in;
   logic [7:0]     kind_ff, kind_in;
   logic [7:0]     crc_ff, crc_in;
   frame_data_type store_ff, store_in;
   logic           accept;
   logic [7:0]     b;
   logic [6:0]     store_offset;
   logic [8:0]     len_plus1;

   // A byte is taken whenever the queue has room for a possible frame.
   assign req.ready    = !q_full;
   assign accept       = req.valid && req.ready;
   assign b            = req.rx_byte;
   assign store_offset = pos_ff - 7'(STORE_FIRST);
   assign len_plus1    = {1'b0, len_ff} + 9'd1;
   assign push_data    = store_in;

   // Parser next state.
   always_comb begin
      pos_in   = pos_ff;
      len_in   = len_ff;
      kind_in  = kind_ff;
      crc_in   = crc_ff;
      store_in = store_ff;
      push     = 1'b0;
      if (accept) begin
         if (pos_ff == 7'd0) begin
            if (b == cfg.sync_value) begin
               pos_in = 7'd1;
               crc_in = 8'd0;
            end
         end else if (pos_ff == 7'd1) begin
            len_in = b;
            if (b < 8'd2 || b > 8'(MAX_FRAME - 2)) begin
               pos_in = 7'd0;
            end else begin
               pos_in = 7'd2;
            end
         end else if ({2'b00, pos_ff} > len_plus1) begin
            pos_in = 7'd0;
         end else begin
            if (pos_ff == 7'd2) begin
               kind_in = b;
            end
            if (pos_ff >= 7'(STORE_FIRST) && pos_ff < 7'(STORE_FIRST + STORE_DEPTH)) begin
               store_in[store_offset[4:0]] = b;
            end
            if ({1'b0, pos_ff} <= len_ff) begin
               crc_in = crc8_update(crc_ff, b);
               pos_in = pos_ff + 7'd1;
            end else begin
               // Check byte: emit only on a CRC match with the channels type.
               pos_in = 7'd0;
               push   = (b == crc_ff) && (kind_ff == cfg.channels_type);
            end
         end
      end
   end

   // Parser registers; the payload store is cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         len_ff   <= '0;
         kind_ff  <= '0;
         crc_ff   <= '0;
         store_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         kind_ff  <= kind_in;
         crc_ff   <= crc_in;
         store_ff <= store_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/crsf_queue.sv =====
// ============================================================================
// crsf_queue
// Small FIFO of frame snapshots between the parser and the emitter.
// DEPTH must be a power of two so the pointers wrap on their own.
// ============================================================================
`default_nettype none

`include "crsf_rc_frame_parser_core_assert.svh"

module crsf_queue
   import crsf_pkg::*;
#(
   parameter int WIDTH = 176,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  head_valid,
   output logic                  full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;

   assign head_data  = mem_ff[rd_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CW'(DEPTH));

   // Pointer and fill count update.
   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop  ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Snapshot storage; no reset needed.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   `CRSF_ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !full)
   `CRSF_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, head_valid)
   `CRSF_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == CW'($past(count_ff) + 1'b1))

endmodule

`default_nettype wire

// ===== rtl/core/crsf_back.sv =====
// ============================================================================
// crsf_back
// Channel emitter: unpacks sixteen 11-bit channels from the queue head,
// one per beat, into a registered output stage.
// ============================================================================
`default_nettype none

module crsf_back
   import crsf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire frame_data_type head_data,
   input  wire logic           head_valid,
   output logic                pop,
   crsf_rsp_if.source          rsp
);

   logic [FRAME_BITS-1:0] frame_bits;
   logic [3:0]            chan_ff, chan_in;
   logic                  valid_ff, valid_in;
   logic [3:0]            number_ff, number_in;
   logic [10:0]           value_ff, value_in;
   logic                  final_ff, final_in;
   logic [7:0]            bit_base;
   logic                  load;

   assign frame_bits = head_data;
   assign bit_base   = 8'(chan_ff * CHANNEL_BITS);
   assign load       = head_valid && (!valid_ff || rsp.ready);
   assign pop        = load && (chan_ff == 4'(NUM_CHANNELS - 1));

   // Output stage refill.
   always_comb begin
      chan_in   = chan_ff;
      valid_in  = valid_ff;
      number_in = number_ff;
      value_in  = value_ff;
      final_in  = final_ff;
      if (load) begin
         valid_in  = 1'b1;
         number_in = chan_ff;
         value_in  = frame_bits[bit_base +: CHANNEL_BITS];
         final_in  = (chan_ff == 4'(NUM_CHANNELS - 1));
         chan_in   = chan_ff + 4'd1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         chan_ff  <= chan_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      number_ff <= number_in;
      value_ff  <= value_in;
      final_ff  <= final_in;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.channel_number = number_ff;
   assign rsp.channel_value  = value_ff;
   assign rsp.final_channel  = final_ff;

endmodule

`default_nettype wire
